// File: rtl/core/vfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg
// shared constants, codes and controller/datapath interface types for the
// voxel face culler
// ----------------------------------------------------------------------------
package vfc_pkg;

    // chunk geometry
    localparam int SIZE_X = 16;
    localparam int SIZE_Y = 256;
    localparam int SIZE_Z = 16;

    // the map is kept as rows of SIZE_Z flags, one row per (x, y)
    localparam int ROW_DEPTH = SIZE_X * SIZE_Y;
    localparam int ROW_W     = $clog2(ROW_DEPTH);
    localparam int Z_W       = $clog2(SIZE_Z);

    // field widths
    localparam int MODE_W  = 2;
    localparam int PX_W    = 4;
    localparam int PY_W    = 8;
    localparam int PZ_W    = 4;
    localparam int VAL_W   = 32;
    localparam int SIDE_W  = 3;
    localparam int COUNT_W = 19;
    localparam int BASE_W  = 21;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_STORE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXAMINE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    // side codes
    localparam logic [SIDE_W-1:0] SIDE_ZM = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_ZP = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_YM = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_YP = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_XM = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_XP = 3'd5;
    localparam int NUM_SIDES = 6;

    // which map row a read fetches
    typedef enum logic [2:0] {
        RD_CENTER,
        RD_YM,
        RD_YP,
        RD_XM,
        RD_XP
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clear;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    st_write;
        logic    clr_step;
        logic    emit_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              in_range;
        logic              clr_last;
        logic              face_any;
        logic              face_last;
        logic              out_free;
    } dp_sts_t;

endpackage

// File: rtl/core/voxel_face_culler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler_unit
// keeps a chunk of solid/empty flags and emits one record per visible face
// of an examined voxel
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                          tuser  tlast
// s_       in   pos_x, pos_y, pos_z, voxel_value (48 bits)  mode   -
// m_       out  face_x, face_y, face_z, side, base_vertex   -      last
//
// store reads and rewrites the map row; examine reads the center and neighbor rows,
// then emits its faces; clear and unused modes stay in idle; the single map read
// port sets the 5 row reads. after reset a clearing pass writes SIZE_X*SIZE_Y rows
// (4096), one per cycle, with s_tready low
// m_tready low holds face emission; the output register keeps the final
// face while the next transaction is taken
// ----------------------------------------------------------------------------
module voxel_face_culler_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vfc_pkg::S_DATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, voxel_value
    input  logic [vfc_pkg::MODE_W-1:0]   s_tuser,  // mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vfc_pkg::M_DATA_W-1:0] m_tdata,  // face_x, face_y, face_z, side, base_vertex
    output logic                         m_tlast
);

    vfc_pkg::dp_cmd_t cmd;
    vfc_pkg::dp_sts_t sts;

    vfc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    vfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// File: rtl/core/vfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/vfc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_datapath
// solid map, neighbor capture, face selection, face counter and the
// output register of the voxel face culler
// ----------------------------------------------------------------------------
module vfc_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vfc_pkg::dp_cmd_t             cmd,
    output vfc_pkg::dp_sts_t             sts,
    input  logic [vfc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [vfc_pkg::MODE_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vfc_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);

    localparam int RW = vfc_pkg::ROW_W;
    localparam int ZW = vfc_pkg::Z_W;
    localparam int NS = vfc_pkg::NUM_SIDES;

    // incoming transaction fields
    logic [vfc_pkg::PX_W-1:0]  in_x;
    logic [vfc_pkg::PY_W-1:0]  in_y;
    logic [vfc_pkg::PZ_W-1:0]  in_z;
    logic [vfc_pkg::VAL_W-1:0] in_val;

    assign in_x   = s_tdata[3:0];
    assign in_y   = s_tdata[11:4];
    assign in_z   = s_tdata[15:12];
    assign in_val = s_tdata[47:16];

    // item registers
    logic [vfc_pkg::PX_W-1:0] x_reg;
    logic [vfc_pkg::PY_W-1:0] y_reg;
    logic [vfc_pkg::PZ_W-1:0] z_reg;
    logic                     val_nz_reg;
    logic [RW-1:0]            row_reg;

    // neighbor flags and progress
    logic [NS-1:0] nb_reg, nb_next;
    logic [NS-1:0] done_reg, done_next;
    logic          solid_reg, solid_next;
    logic          rd_pend_reg;
    vfc_pkg::rd_sel_t rd_tag_reg;

    logic [vfc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [RW-1:0]               clr_addr_reg;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [vfc_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                         m_tlast_reg;

    // edges
    logic at_xlo, at_xhi, at_ylo, at_yhi, at_zlo, at_zhi;
    logic [ZW-1:0] z_idx, z_dn, z_up;

    assign at_xlo = (x_reg == '0);
    assign at_xhi = (32'(x_reg) == 32'(vfc_pkg::SIZE_X - 1));
    assign at_ylo = (y_reg == '0);
    assign at_yhi = (32'(y_reg) == 32'(vfc_pkg::SIZE_Y - 1));
    assign at_zlo = (z_reg == '0);
    assign at_zhi = (32'(z_reg) == 32'(vfc_pkg::SIZE_Z - 1));
    assign z_idx  = ZW'(z_reg);
    assign z_dn   = z_idx - ZW'(1);
    assign z_up   = z_idx + ZW'(1);

    // map memory
    logic [RW-1:0]                 rd_addr, wr_addr;
    logic [vfc_pkg::SIZE_Z-1:0]    rd_data, wr_data, st_row;
    logic                          wr_en;

    always_comb begin
        case (cmd.rd_sel)
            vfc_pkg::RD_YM: rd_addr = at_ylo ? row_reg : row_reg - RW'(1);
            vfc_pkg::RD_YP: rd_addr = at_yhi ? row_reg : row_reg + RW'(1);
            vfc_pkg::RD_XM: rd_addr = at_xlo ? row_reg : row_reg - RW'(vfc_pkg::SIZE_Y);
            vfc_pkg::RD_XP: rd_addr = at_xhi ? row_reg : row_reg + RW'(vfc_pkg::SIZE_Y);
            default:        rd_addr = row_reg;
        endcase
    end

    always_comb begin
        st_row        = rd_data;
        st_row[z_idx] = val_nz_reg;
    end

    assign wr_en   = cmd.clr_step | cmd.st_write;
    assign wr_addr = cmd.clr_step ? clr_addr_reg : row_reg;
    assign wr_data = cmd.clr_step ? '0 : st_row;

    vfc_ram #(
        .WIDTH (vfc_pkg::SIZE_Z),
        .DEPTH (vfc_pkg::ROW_DEPTH)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // capture of returned rows
    always_comb begin
        nb_next    = nb_reg;
        solid_next = solid_reg;
        if (rd_pend_reg) begin
            case (rd_tag_reg)
                vfc_pkg::RD_CENTER: begin
                    solid_next              = rd_data[z_idx];
                    nb_next[vfc_pkg::SIDE_ZM] = !at_zlo && rd_data[z_dn];
                    nb_next[vfc_pkg::SIDE_ZP] = !at_zhi && rd_data[z_up];
                end
                vfc_pkg::RD_YM: nb_next[vfc_pkg::SIDE_YM] = !at_ylo && rd_data[z_idx];
                vfc_pkg::RD_YP: nb_next[vfc_pkg::SIDE_YP] = !at_yhi && rd_data[z_idx];
                vfc_pkg::RD_XM: nb_next[vfc_pkg::SIDE_XM] = !at_xlo && rd_data[z_idx];
                vfc_pkg::RD_XP: nb_next[vfc_pkg::SIDE_XP] = !at_xhi && rd_data[z_idx];
                default: ;
            endcase
        end
    end

    // visible face selection, lowest side first
    logic [NS-1:0]             vis, pick_oh;
    logic [vfc_pkg::SIDE_W-1:0] pick_side;

    assign vis = solid_reg ? (~nb_reg & ~done_reg) : '0;

    always_comb begin
        pick_oh   = '0;
        pick_side = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (vis[i]) begin
                pick_oh   = '0;
                pick_oh[i] = 1'b1;
                pick_side = vfc_pkg::SIDE_W'(i);
            end
        end
    end

    assign done_next  = cmd.load_item ? '0 : (cmd.emit_load ? (done_reg | pick_oh) : done_reg);
    assign count_next = (cmd.cnt_clear) ? '0 :
                        (cmd.emit_load ? count_reg + vfc_pkg::COUNT_W'(1) : count_reg);

    always_comb begin
        if (cmd.emit_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg  <= 1'b0;
            count_reg    <= '0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
            done_reg     <= '0;
            solid_reg    <= 1'b0;
        end else begin
            rd_pend_reg  <= cmd.rd_en;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            done_reg     <= done_next;
            solid_reg    <= cmd.load_item ? 1'b0 : solid_next;
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_tag_reg <= cmd.rd_sel;
        nb_reg     <= nb_next;
        if (cmd.load_item) begin
            x_reg      <= in_x;
            y_reg      <= in_y;
            z_reg      <= in_z;
            val_nz_reg <= (in_val != '0);
            row_reg    <= RW'(in_x) * RW'(vfc_pkg::SIZE_Y) + RW'(in_y);
        end
        if (cmd.emit_load) begin
            m_tdata_reg <= {{count_reg, 2'b00}, pick_side, z_reg, y_reg, x_reg};
            m_tlast_reg <= ((vis & ~pick_oh) == '0);
        end
    end

    assign sts.in_mode   = s_tuser;
    assign sts.in_range  = (32'(in_x) < 32'(vfc_pkg::SIZE_X)) &&
                           (32'(in_y) < 32'(vfc_pkg::SIZE_Y)) &&
                           (32'(in_z) < 32'(vfc_pkg::SIZE_Z));
    assign sts.clr_last  = (clr_addr_reg == RW'(vfc_pkg::ROW_DEPTH - 1));
    assign sts.face_any  = (vis != '0);
    assign sts.face_last = ((vis & ~pick_oh) == '0);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/core/vfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_ctrl
// sequencer for map clearing, store, neighbor reads and face emission
// ----------------------------------------------------------------------------
module vfc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output vfc_pkg::dp_cmd_t cmd,
    input  vfc_pkg::dp_sts_t sts
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ST_RD,
        S_ST_WR,
        S_RD_C,
        S_RD_YM,
        S_RD_YP,
        S_RD_XM,
        S_RD_XP,
        S_RD_WAIT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_sel    = vfc_pkg::RD_CENTER;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clear = (sts.in_mode == vfc_pkg::MODE_CLEAR);
                    if (sts.in_range && sts.in_mode == vfc_pkg::MODE_STORE) begin
                        state_next = S_ST_RD;
                    end else if (sts.in_range && sts.in_mode == vfc_pkg::MODE_EXAMINE) begin
                        state_next = S_RD_C;
                    end
                end
            end
            S_ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_ST_WR;
            end
            S_ST_WR: begin
                cmd.st_write = 1'b1;
                state_next   = S_IDLE;
            end
            S_RD_C: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD_YM;
            end
            S_RD_YM: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = vfc_pkg::RD_YM;
                state_next = S_RD_YP;
            end
            S_RD_YP: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = vfc_pkg::RD_YP;
                state_next = S_RD_XM;
            end
            S_RD_XM: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = vfc_pkg::RD_XM;
                state_next = S_RD_XP;
            end
            S_RD_XP: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = vfc_pkg::RD_XP;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!sts.face_any) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (sts.face_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: bench/tb_voxel_face_culler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_culler_unit
// drives store, examine, clear and unused-mode transactions into the face
// culler, keeps its own copy of the solid map and the face counter, and
// checks every emitted face record in order against the predicted ones; a
// short directed table runs first, then clustered random traffic with random
// stalls on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module tb_voxel_face_culler_unit;
    import vfc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int FROM_MODEL   = -1;
    localparam int RAND_ITEMS   = 345;
    localparam int CALM_ITEMS   = 50;
    localparam int HOLD_AT_ITEM = 60;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int MAP_CELLS    = SIZE_X * SIZE_Y * SIZE_Z;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PX_W-1:0]   x;
        logic [PY_W-1:0]   y;
        logic [PZ_W-1:0]   z;
        logic [VAL_W-1:0]  value;
    } stim_t;

    typedef struct packed {
        logic [PX_W-1:0]   x;
        logic [PY_W-1:0]   y;
        logic [PZ_W-1:0]   z;
        logic [SIDE_W-1:0] side;
        logic [BASE_W-1:0] base;
        logic              last;
    } face_rec_t;

    typedef struct {
        stim_t item;
        int    faces;       // visible side mask, bit per side code, or FROM_MODEL
        int    first_base;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // pos_x, pos_y, pos_z, voxel_value
    logic [MODE_W-1:0]   s_tuser;   // mode
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // face_x, face_y, face_z, side, base_vertex
    logic                m_tlast;

    bit                 solid [0:MAP_CELLS-1];
    logic [COUNT_W-1:0] face_ctr = '0;
    face_rec_t          model_faces[$];
    face_rec_t          pending_faces[$];
    row_t               dir_rows[$];
    int                 errors = 0;
    logic               calm = 1'b0;
    logic               hold_req = 1'b0;

    voxel_face_culler_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int cell_index(int x, int y, int z);
        return (x * SIZE_Y + y) * SIZE_Z + z;
    endfunction

    // past the chunk edge reads as empty
    function automatic bit occupied(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= SIZE_X || y >= SIZE_Y || z >= SIZE_Z)
            return 1'b0;
        return solid[cell_index(x, y, z)];
    endfunction

    task automatic add_model_face(input face_rec_t rec);
        model_faces.insert(model_faces.size(), rec);
    endtask

    task automatic add_pending_face(input face_rec_t rec);
        pending_faces.insert(pending_faces.size(), rec);
    endtask

    task automatic add_row(input row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic cull_voxel(input stim_t it);
        face_rec_t rec;
        int        s;
        int        nx;
        int        ny;
        int        nz;
        case (it.mode)
            MODE_CLEAR: begin
                face_ctr = '0;
            end
            MODE_STORE: begin
                solid[cell_index(it.x, it.y, it.z)] = (it.value != '0);
            end
            MODE_EXAMINE: begin
                if (solid[cell_index(it.x, it.y, it.z)]) begin
                    for (s = 0; s < NUM_SIDES; s++) begin
                        nx = it.x;
                        ny = it.y;
                        nz = it.z;
                        case (SIDE_W'(s))
                            SIDE_ZM: nz = nz - 1;
                            SIDE_ZP: nz = nz + 1;
                            SIDE_YM: ny = ny - 1;
                            SIDE_YP: ny = ny + 1;
                            SIDE_XM: nx = nx - 1;
                            default: nx = nx + 1;
                        endcase
                        if (!occupied(nx, ny, nz)) begin
                            rec.x    = it.x;
                            rec.y    = it.y;
                            rec.z    = it.z;
                            rec.side = SIDE_W'(s);
                            rec.base = {face_ctr, 2'b00};
                            rec.last = 1'b0;
                            add_model_face(rec);
                            face_ctr = face_ctr + 1'b1;
                        end
                    end
                    if (model_faces.size() != 0)
                        model_faces[model_faces.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic row_t mk_row(logic [MODE_W-1:0] mode, int x, int y, int z,
                                    logic [VAL_W-1:0] value, int faces, int first_base);
        row_t r;
        r.item.mode  = mode;
        r.item.x     = x[PX_W-1:0];
        r.item.y     = y[PY_W-1:0];
        r.item.z     = z[PZ_W-1:0];
        r.item.value = value;
        r.faces      = faces;
        r.first_base = first_base;
        return r;
    endfunction

    // positions cluster near the chunk edges (and mid-height in y) so neighbors interact
    function automatic stim_t rand_item();
        stim_t it;
        int    pick;
        int    cx;
        int    cy;
        int    cz;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.mode = MODE_STORE;
        else if (pick < 85)
            it.mode = MODE_EXAMINE;
        else if (pick < 93)
            it.mode = MODE_CLEAR;
        else
            it.mode = MODE_UNUSED;
        cx = ($urandom_range(0, 1) ? 13 : 0) + $urandom_range(0, 2);
        cz = ($urandom_range(0, 1) ? 13 : 0) + $urandom_range(0, 2);
        case ($urandom_range(0, 2))
            0:       cy = $urandom_range(0, 2);
            1:       cy = 253 + $urandom_range(0, 2);
            default: cy = 127 + $urandom_range(0, 2);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            cx = $urandom_range(0, SIZE_X - 1);
            cy = $urandom_range(0, SIZE_Y - 1);
            cz = $urandom_range(0, SIZE_Z - 1);
        end
        it.x = cx[PX_W-1:0];
        it.y = cy[PY_W-1:0];
        it.z = cz[PZ_W-1:0];
        case ($urandom_range(0, 2))
            0:       it.value = '0;
            1:       it.value = 32'd1 << $urandom_range(0, 31);
            default: it.value = $urandom;
        endcase
        return it;
    endfunction

    task automatic send_item(input stim_t it, input int faces, input int first_base);
        face_rec_t         rec;
        logic [BASE_W-1:0] base;
        int                s;
        int                i;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.value, it.z, it.y, it.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_faces.delete();
        cull_voxel(it);
        if (faces == FROM_MODEL) begin
            for (i = 0; i < model_faces.size(); i++)
                add_pending_face(model_faces[i]);
        end else begin
            base = BASE_W'(first_base);
            for (s = 0; s < NUM_SIDES; s++) begin
                if (faces[s]) begin
                    rec.x    = it.x;
                    rec.y    = it.y;
                    rec.z    = it.z;
                    rec.side = SIDE_W'(s);
                    rec.base = base;
                    rec.last = (faces >> (s + 1)) == 0;
                    add_pending_face(rec);
                    base = base + 3'd4;
                end
            end
        end
    endtask

    initial begin : stimulus
        int n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_STORE;

        // empty chunk after reset, unused mode, lone voxels at both corners
        add_row(mk_row(MODE_EXAMINE,  0,   0,  0, 32'h0,        0, 0));
        add_row(mk_row(MODE_UNUSED,  15, 255, 15, 32'hFFFF_FFFF, 0, 0));
        add_row(mk_row(MODE_STORE,    0,   0,  0, 32'h1,        0, 0));
        add_row(mk_row(MODE_EXAMINE,  0,   0,  0, 32'hFFFF_FFFF, 6'b111111, 0));
        add_row(mk_row(MODE_STORE,   15, 255, 15, 32'hFFFF_FFFF, 0, 0));
        add_row(mk_row(MODE_EXAMINE, 15, 255, 15, 32'h0,        6'b111111, 24));
        add_row(mk_row(MODE_CLEAR,    7, 100,  3, 32'h5,        0, 0));
        add_row(mk_row(MODE_EXAMINE, 15, 255, 15, 32'h0,        6'b111111, 0));
        // neighbor below hides the -y face
        add_row(mk_row(MODE_STORE,   15, 254, 15, 32'h8000_0000, 0, 0));
        add_row(mk_row(MODE_EXAMINE, 15, 255, 15, 32'h0,        6'b111011, 24));
        add_row(mk_row(MODE_STORE,   15, 254, 15, 32'h0,        0, 0));
        add_row(mk_row(MODE_EXAMINE, 15, 254, 15, 32'h0,        0, 0));
        // fully enclosed voxel emits nothing
        add_row(mk_row(MODE_STORE,    8, 128,  8, 32'h2,        0, 0));
        add_row(mk_row(MODE_STORE,    8, 128,  7, 32'h4,        0, 0));
        add_row(mk_row(MODE_STORE,    8, 128,  9, 32'h10,       0, 0));
        add_row(mk_row(MODE_STORE,    8, 127,  8, 32'h100,      0, 0));
        add_row(mk_row(MODE_STORE,    8, 129,  8, 32'h1_0000,   0, 0));
        add_row(mk_row(MODE_STORE,    7, 128,  8, 32'h100_0000, 0, 0));
        add_row(mk_row(MODE_STORE,    9, 128,  8, 32'h7FFF_FFFF, 0, 0));
        add_row(mk_row(MODE_EXAMINE,  8, 128,  8, 32'h0,        0, 0));
        add_row(mk_row(MODE_EXAMINE,  9, 128,  8, 32'h0,        FROM_MODEL, 0));
        add_row(mk_row(MODE_EXAMINE,  8, 129,  8, 32'h0,        FROM_MODEL, 0));
        add_row(mk_row(MODE_STORE,    0,   0,  0, 32'h0,        0, 0));
        add_row(mk_row(MODE_EXAMINE,  0,   0,  0, 32'h0,        0, 0));
        add_row(mk_row(MODE_EXAMINE, 15, 255, 15, 32'h0,        FROM_MODEL, 0));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].faces, dir_rows[i].first_base);
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM)
                hold_req <= 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            send_item(rand_item(), FROM_MODEL, 0);
        end
        s_tvalid <= 1'b0;

        while (pending_faces.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : sink_pacing
        bit hold_done;
        int hold_cnt;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                // long hold-off so the block backs up and stalls its input
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++)
                    @(posedge aclk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : face_check
        face_rec_t got;
        face_rec_t want;
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            got.x    = m_tdata[3:0];
            got.y    = m_tdata[11:4];
            got.z    = m_tdata[15:12];
            got.side = m_tdata[18:16];
            got.base = m_tdata[39:19];
            got.last = m_tlast;
            if (pending_faces.size() == 0) begin
                $display("%0t unexpected face transaction: x=%0d y=%0d z=%0d side=%0d base=%0d last=%0b",
                         $time, got.x, got.y, got.z, got.side, got.base, got.last);
                errors++;
            end else begin
                want = pending_faces.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.side !== want.side || got.base !== want.base ||
                    got.last !== want.last) begin
                    $display("%0t face mismatch: expected x=%0d y=%0d z=%0d side=%0d base=%0d last=%0b",
                             $time, want.x, want.y, want.z, want.side, want.base, want.last);
                    $display("%0t                actual   x=%0d y=%0d z=%0d side=%0d base=%0d last=%0b",
                             $time, got.x, got.y, got.z, got.side, got.base, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("%0t timeout after %0d cycles, %0d faces still expected",
                 $time, cycle_cnt, pending_faces.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
